// ----- rtl/core/imubcf_pkg.sv -----
// ============================================================================
// imubcf_pkg
// Shared types and constants for the motion sensor offset calibration and
// framing block.
// ============================================================================
`default_nettype none

package imubcf_pkg;

    // Field widths fixed by the sample format
    localparam int DATA_W = 16;
    localparam int ID_W   = 3;
    localparam int AXES   = 6;
    localparam int AXIS_W = 3;

    // Signed running sums; wide enough for up to 255 full-scale samples
    localparam int SUM_W = 24;

    // Defaults for the top-level parameters
    localparam int CAL_SAMPLES_DEF = 100;
    localparam int NUM_SENSORS_DEF = 8;

    // Output frame layout
    localparam int FRAME_LEN   = 16;
    localparam int FRAME_IDX_W = 4;

    localparam logic [FRAME_IDX_W-1:0] IDX_ID   = 4'd0;
    localparam logic [FRAME_IDX_W-1:0] IDX_SYNC = 4'd13;
    localparam logic [FRAME_IDX_W-1:0] IDX_CR   = 4'd14;
    localparam logic [FRAME_IDX_W-1:0] IDX_LF   = 4'd15;

    localparam logic [7:0] BYTE_SYNC = 8'hFF;
    localparam logic [7:0] BYTE_CR   = 8'd13;
    localparam logic [7:0] BYTE_LF   = 8'd10;

    // Sample kind
    localparam logic FUNC_CAL  = 1'b0;
    localparam logic FUNC_MEAS = 1'b1;

    // Offset division sequencer
    typedef enum logic {
        DIV_IDLE,
        DIV_RUN
    } div_state_t;

    typedef logic signed [DATA_W-1:0] axis_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

endpackage

`default_nettype wire

// ----- rtl/core/imubcf_ram.sv -----
// ============================================================================
// imubcf_ram
// Generic single-write, single-read synchronous RAM with registered read
// data. Read data holds until the next read.
// ============================================================================
`default_nettype none

module imubcf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/core/imu_bias_calibrate_and_frame_top.sv -----
// Measurement item: it waits in a registered stage until the serializer is free,
// then its frame goes out as 16 bytes at one per cycle while out_stall is low;
// one item can wait while a frame is sent. Calibration items are taken one per
// cycle while in_stall is low; the item that completes a calibration stalls
// input while the divide pipeline writes the offset row. Reset clears control state and the per-sensor row
// valid bits, so offsets read as zero at once; there is no clearing pass.
// ============================================================================
// imu_bias_calibrate_and_frame_top
// Averages calibration samples into per-sensor offsets held in a row memory,
// subtracts them from measurement samples and serializes 16-byte frames.
// ============================================================================
`default_nettype none

module imu_bias_calibrate_and_frame_top #(
    parameter int CAL_SAMPLES = imubcf_pkg::CAL_SAMPLES_DEF,
    parameter int NUM_SENSORS = imubcf_pkg::NUM_SENSORS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic                                  func,
    input  wire logic [imubcf_pkg::ID_W-1:0]           sensor_id,
    input  wire logic signed [imubcf_pkg::DATA_W-1:0]  acc_x,
    input  wire logic signed [imubcf_pkg::DATA_W-1:0]  acc_y,
    input  wire logic signed [imubcf_pkg::DATA_W-1:0]  acc_z,
    input  wire logic signed [imubcf_pkg::DATA_W-1:0]  gyr_x,
    input  wire logic signed [imubcf_pkg::DATA_W-1:0]  gyr_y,
    input  wire logic signed [imubcf_pkg::DATA_W-1:0]  gyr_z,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic [7:0]                                 frame_byte,
    output logic                                       last
);

    import imubcf_pkg::*;

    localparam int ROW_AW    = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
    localparam int ROW_W     = AXES * DATA_W;
    localparam int CNT_W     = $clog2(CAL_SAMPLES + 1);
    localparam int MAG_W     = SUM_W - 1;
    localparam int MUL_W     = MAG_W + 1;
    localparam int PROD_W    = MAG_W + MUL_W;
    localparam int DIV_SHIFT = MAG_W + $clog2(CAL_SAMPLES);
    // ceil(2^DIV_SHIFT / CAL_SAMPLES): exact floor quotient for all magnitudes
    localparam logic [63:0] MUL_C64 =
        ((64'd1 << DIV_SHIFT) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES);
    localparam logic [MUL_W-1:0] MUL_C = MUL_C64[MUL_W-1:0];

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    axis_t raw_in [AXES];
    logic  in_accept;
    logic  in_range;
    logic  cal_accept;
    logic  meas_accept;

    assign raw_in[0] = acc_x;
    assign raw_in[1] = acc_y;
    assign raw_in[2] = acc_z;
    assign raw_in[3] = gyr_x;
    assign raw_in[4] = gyr_y;
    assign raw_in[5] = gyr_z;

    assign in_accept   = in_valid && !in_stall;
    assign in_range    = ({1'b0, sensor_id} < (ID_W + 1)'(NUM_SENSORS));
    assign cal_accept  = in_accept && (func == FUNC_CAL) && in_range;
    assign meas_accept = in_accept && (func == FUNC_MEAS);

    // ------------------------------------------------------------------
    // Offset row memory, one row of six offsets per sensor
    // ------------------------------------------------------------------
    logic                 ram_we;
    logic [ROW_AW-1:0]    ram_waddr;
    logic [ROW_W-1:0]     ram_wdata;
    logic                 ram_re;
    logic [ROW_W-1:0]     ram_rdata;
    logic                 row_valid_reg [NUM_SENSORS];

    assign ram_re = meas_accept && in_range;

    imubcf_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SENSORS),
        .AW    (ROW_AW)
    ) u_offset_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (sensor_id[ROW_AW-1:0]),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Calibration accumulation
    // ------------------------------------------------------------------
    sum_t              sums_reg [AXES];
    sum_t              sums_next [AXES];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [ID_W-1:0]   cal_sensor_reg;
    logic [ID_W-1:0]   cal_sensor_next;
    logic              restart;
    logic [CNT_W-1:0]  count_base;
    logic [CNT_W-1:0]  count_inc;
    logic              cal_done;

    div_state_t        div_state_reg;
    div_state_t        div_state_next;
    logic [AXIS_W-1:0] issue_idx_reg;
    logic [AXIS_W-1:0] collect_idx_reg;
    logic              v1_reg;
    logic              v2_reg;
    logic [MAG_W-1:0]  mag_reg;
    logic              neg1_reg;
    logic              neg2_reg;
    logic [PROD_W-1:0] prod_reg;
    axis_t             row_buf_reg [AXES];
    logic [PROD_W-1:0] quo_shift;
    logic [DATA_W-1:0] quo_mag;
    logic [DATA_W-1:0] quo;
    sum_t              div_sum;

    assign restart    = (count_reg != '0) && (sensor_id != cal_sensor_reg);
    assign count_base = restart ? '0 : count_reg;
    assign count_inc  = count_base + 1'b1;
    assign cal_done   = cal_accept && (count_inc >= CNT_W'(CAL_SAMPLES));

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            sums_next[a] = sums_reg[a];
        end
        count_next      = count_reg;
        cal_sensor_next = cal_sensor_reg;
        if (cal_accept)
        begin
            // Restart the sums when a different sensor shows up mid-run
            for (int a = 0; a < AXES; a++)
            begin
                sums_next[a] = (restart ? '0 : sums_reg[a])
                             + {{(SUM_W - DATA_W){raw_in[a][DATA_W-1]}}, raw_in[a]};
            end
            if (count_base == '0)
            begin
                cal_sensor_next = sensor_id;
            end
            count_next = cal_done ? '0 : count_inc;
        end
        else if (ram_we)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                sums_next[a] = '0;
            end
        end
    end

    // Divide sequencer: one axis issued per cycle through abs, multiply, shift
    always_comb
    begin
        div_state_next = div_state_reg;
        ram_we         = 1'b0;
        unique case (div_state_reg)
            DIV_IDLE:
            begin
                if (cal_done)
                begin
                    div_state_next = DIV_RUN;
                end
            end
            DIV_RUN:
            begin
                if (collect_idx_reg == AXIS_W'(AXES))
                begin
                    ram_we         = 1'b1;
                    div_state_next = DIV_IDLE;
                end
            end
            default:
            begin
                div_state_next = DIV_IDLE;
            end
        endcase
    end

    assign div_sum   = sums_reg[issue_idx_reg];
    assign quo_shift = prod_reg >> DIV_SHIFT;
    assign quo_mag   = quo_shift[DATA_W-1:0];
    assign quo       = neg2_reg ? (~quo_mag + 1'b1) : quo_mag;
    assign ram_waddr = cal_sensor_reg[ROW_AW-1:0];

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            ram_wdata[a*DATA_W +: DATA_W] = row_buf_reg[a];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                sums_reg[a] <= '0;
            end
            count_reg       <= '0;
            cal_sensor_reg  <= '0;
            div_state_reg   <= DIV_IDLE;
            issue_idx_reg   <= '0;
            collect_idx_reg <= '0;
            v1_reg          <= 1'b0;
            v2_reg          <= 1'b0;
            for (int s = 0; s < NUM_SENSORS; s++)
            begin
                row_valid_reg[s] <= 1'b0;
            end
        end
        else
        begin
            for (int a = 0; a < AXES; a++)
            begin
                sums_reg[a] <= sums_next[a];
            end
            count_reg      <= count_next;
            cal_sensor_reg <= cal_sensor_next;
            div_state_reg  <= div_state_next;
            if (div_state_reg == DIV_IDLE)
            begin
                issue_idx_reg   <= '0;
                collect_idx_reg <= '0;
                v1_reg          <= 1'b0;
                v2_reg          <= 1'b0;
            end
            else
            begin
                v1_reg <= (issue_idx_reg < AXIS_W'(AXES));
                v2_reg <= v1_reg;
                if (issue_idx_reg < AXIS_W'(AXES))
                begin
                    issue_idx_reg <= issue_idx_reg + 1'b1;
                end
                if (v2_reg)
                begin
                    collect_idx_reg <= collect_idx_reg + 1'b1;
                end
            end
            if (ram_we)
            begin
                row_valid_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        neg1_reg <= div_sum[SUM_W-1];
        mag_reg  <= div_sum[SUM_W-1] ? MAG_W'(-div_sum) : div_sum[MAG_W-1:0];
        neg2_reg <= neg1_reg;
        prod_reg <= PROD_W'(mag_reg) * PROD_W'(MUL_C);
        if (v2_reg)
        begin
            row_buf_reg[collect_idx_reg] <= quo;
        end
    end

    // ------------------------------------------------------------------
    // Measurement stage: the item is registered while its offset row is read
    // ------------------------------------------------------------------
    logic              s1_valid_reg;
    logic              s1_use_off_reg;
    logic [ID_W-1:0]   s1_id_reg;
    axis_t             s1_raw_reg [AXES];
    logic              s1_move;

    logic              frame_free;
    logic              frame_done;
    logic              out_valid_reg;
    logic [FRAME_IDX_W-1:0] byte_idx_reg;
    logic [ID_W-1:0]   frame_id_reg;
    logic [DATA_W-1:0] frame_vals_reg [AXES];

    assign frame_done = out_valid_reg && !out_stall && (byte_idx_reg == IDX_LF);
    assign frame_free = !out_valid_reg || frame_done;
    assign s1_move    = s1_valid_reg && frame_free;
    // Hold input while dividing or while the waiting item cannot move on
    assign in_stall   = (div_state_reg != DIV_IDLE) || (s1_valid_reg && !frame_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            byte_idx_reg  <= '0;
        end
        else
        begin
            if (meas_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
                byte_idx_reg  <= IDX_ID;
            end
            else if (frame_done)
            begin
                out_valid_reg <= 1'b0;
            end
            else if (out_valid_reg && !out_stall)
            begin
                byte_idx_reg <= byte_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (meas_accept)
        begin
            s1_id_reg      <= sensor_id;
            s1_use_off_reg <= in_range && row_valid_reg[sensor_id[ROW_AW-1:0]];
            for (int a = 0; a < AXES; a++)
            begin
                s1_raw_reg[a] <= raw_in[a];
            end
        end
        if (s1_move)
        begin
            frame_id_reg <= s1_id_reg;
            for (int a = 0; a < AXES; a++)
            begin
                frame_vals_reg[a] <= s1_raw_reg[a]
                    - (s1_use_off_reg ? ram_rdata[a*DATA_W +: DATA_W] : '0);
            end
        end
    end

    // ------------------------------------------------------------------
    // Frame serializer
    // ------------------------------------------------------------------
    logic [FRAME_IDX_W-1:0] byte_off;
    logic [AXIS_W-1:0]      byte_axis;
    logic [DATA_W-1:0]      byte_word;

    assign byte_off  = byte_idx_reg - 1'b1;
    assign byte_axis = byte_off[FRAME_IDX_W-1:1];
    assign byte_word = frame_vals_reg[byte_axis];

    always_comb
    begin
        unique case (byte_idx_reg)
            IDX_ID:   frame_byte = {{(8 - ID_W){1'b0}}, frame_id_reg};
            IDX_SYNC: frame_byte = BYTE_SYNC;
            IDX_CR:   frame_byte = BYTE_CR;
            IDX_LF:   frame_byte = BYTE_LF;
            // Axis bytes: high byte first
            default:  frame_byte = byte_off[0] ? byte_word[7:0] : byte_word[15:8];
        endcase
    end

    assign out_valid = out_valid_reg;
    assign last      = (byte_idx_reg == IDX_LF);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_accept_while_div: assert property (@(posedge clk) disable iff (!rst_n)
        (div_state_reg != DIV_IDLE) |-> !in_accept)
        else $error("item accepted during offset division");

    a_row_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (collect_idx_reg == AXIS_W'(AXES)) && !v1_reg && !v2_reg)
        else $error("offset row written before all quotients collected");

    a_count_below_target: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < CNT_W'(CAL_SAMPLES))
        else $error("sample count reached target without reset");

    a_frame_starts_at_id: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> out_valid && (byte_idx_reg == IDX_ID))
        else $error("frame did not start on the sensor byte");

    a_waiting_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !frame_free) |=> s1_valid_reg && $stable(s1_id_reg))
        else $error("waiting measurement item lost");

endmodule

`default_nettype wire
